// File: hw/rtl/kcs_pkg.sv
package kcs_pkg;

    localparam int TIME_W     = 48;
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 40;
    localparam int MAG_W      = 34;
    localparam int ITER_W     = 6;

    // Input beat layout, lowest bit first
    localparam int KEY_INDEX_LSB     = 0;
    localparam int KEY_TIME_LSB      = 6;
    localparam int KEY_VALUE_LSB     = 54;
    localparam int QUERY_TIME_LSB    = 86;
    localparam int DEFAULT_VALUE_LSB = 134;

    localparam logic [ITER_W-1:0] MOD_LAST_ITER = 6'd47;
    localparam logic [ITER_W-1:0] DIV_LAST_ITER = 6'd33;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INTERP     = 3'd0,
        ST_NO_KEYS    = 3'd1,
        ST_SINGLE_KEY = 3'd2,
        ST_DEFAULT    = 3'd3,
        ST_ZERO_SPAN  = 3'd4
    } status_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,
        S_RD_LAST,
        S_CHECK,
        S_MOD,
        S_WRAP,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DIV,
        S_RESULT,
        S_FINISH
    } ctrl_state_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_CAPTURE,
        CMD_RD_FIRST,
        CMD_RD_LAST,
        CMD_CHECK,
        CMD_MOD_STEP,
        CMD_WRAP,
        CMD_SRCH_RD,
        CMD_SRCH_CMP,
        CMD_DIV_STEP,
        CMD_INTERP,
        CMD_PUSH
    } dp_cmd_t;

    typedef struct packed {
        logic keys_zero;
        logic keys_one;
        logic span_bad;
        logic wrap_needed;
        logic iter_zero;
        logic match;
        logic last_seg;
        logic out_free;
    } dp_status_t;

endpackage

// File: hw/rtl/keyframe_curve_sampler_core.sv
// Keyframe curve sampler: piecewise linear interpolation over a keyframe store.
// Input stream (s_*): each beat is a load (tuser = 0) or a query (tuser = 1).
// A load writes one keyframe slot and gives no output beat; a load whose slot
// is not below KEY_SLOTS is dropped. A query gives one output beat.
// Output stream (m_*): sample value and status, held in an output register,
// so the core finishes the next load or query while a result still waits.
// Config channel (cfg_*): sets the key count; ready is always high. Write it
// only while the core is idle.
// A query reads the first and last keys, then checks the key count and span;
// no keys, one key or a zero span end the query there. Otherwise a bit-serial
// modulo wraps a time outside the key span, a search compares the segments one
// at a time through the single read port of the key store, and on a match a
// radix-2 scaled divider interpolates; with no matching segment the default
// value is given. A new beat is taken the cycle after the result is registered.
// Reset clears the key count and the output valid; the key store is not
// cleared and a query must not reach slots never loaded. When the receiver
// stalls, the finished result waits in the datapath result register until the
// output register frees up, and no input beat is taken meanwhile.
module keyframe_curve_sampler_core #(
    parameter int KEY_SLOTS = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // key_index[5:0], key_time[53:6], key_value[85:54], query_time[133:86],
    // default_value[165:134], zero pad
    input  logic [kcs_pkg::IN_DATA_W-1:0]     s_tdata,
    // kind[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // sample_value[31:0], status[34:32], zero pad
    output logic [kcs_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kcs_pkg::COUNT_W-1:0]       cfg_data
);

    kcs_pkg::dp_cmd_t    cmd;
    kcs_pkg::dp_status_t status;

    kcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    kcs_datapath #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .status    (status),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    // Key count register takes a write on any cycle
    assign cfg_ready = 1'b1;

endmodule

// File: hw/rtl/kcs_ctrl.sv
module kcs_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_kind,
    input  kcs_pkg::dp_status_t status,
    output logic                in_ready,
    output kcs_pkg::dp_cmd_t    cmd
);

    kcs_pkg::ctrl_state_t state_reg;
    kcs_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kcs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kcs_pkg::S_IDLE:
            begin
                if (in_valid && in_kind == kcs_pkg::KIND_QUERY)
                begin
                    state_next = kcs_pkg::S_RD_FIRST;
                end
            end
            kcs_pkg::S_RD_FIRST: state_next = kcs_pkg::S_RD_LAST;
            kcs_pkg::S_RD_LAST:  state_next = kcs_pkg::S_CHECK;
            kcs_pkg::S_CHECK:
            begin
                if (status.keys_zero || status.keys_one || status.span_bad)
                begin
                    state_next = kcs_pkg::S_FINISH;
                end
                else if (status.wrap_needed)
                begin
                    state_next = kcs_pkg::S_MOD;
                end
                else
                begin
                    state_next = kcs_pkg::S_WRAP;
                end
            end
            kcs_pkg::S_MOD:
            begin
                if (status.iter_zero)
                begin
                    state_next = kcs_pkg::S_WRAP;
                end
            end
            kcs_pkg::S_WRAP:    state_next = kcs_pkg::S_SRCH_RD;
            kcs_pkg::S_SRCH_RD: state_next = kcs_pkg::S_SRCH_CMP;
            kcs_pkg::S_SRCH_CMP:
            begin
                if (status.match)
                begin
                    state_next = kcs_pkg::S_DIV;
                end
                else if (status.last_seg)
                begin
                    state_next = kcs_pkg::S_FINISH;
                end
                else
                begin
                    state_next = kcs_pkg::S_SRCH_RD;
                end
            end
            kcs_pkg::S_DIV:
            begin
                if (status.iter_zero)
                begin
                    state_next = kcs_pkg::S_RESULT;
                end
            end
            kcs_pkg::S_RESULT: state_next = kcs_pkg::S_FINISH;
            kcs_pkg::S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = kcs_pkg::S_IDLE;
                end
            end
            default: state_next = kcs_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = kcs_pkg::CMD_NOP;
        unique case (state_reg)
            kcs_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = (in_kind == kcs_pkg::KIND_QUERY) ? kcs_pkg::CMD_CAPTURE
                                                           : kcs_pkg::CMD_LOAD;
                end
            end
            kcs_pkg::S_RD_FIRST: cmd = kcs_pkg::CMD_RD_FIRST;
            kcs_pkg::S_RD_LAST:  cmd = kcs_pkg::CMD_RD_LAST;
            kcs_pkg::S_CHECK:    cmd = kcs_pkg::CMD_CHECK;
            kcs_pkg::S_MOD:      cmd = kcs_pkg::CMD_MOD_STEP;
            kcs_pkg::S_WRAP:     cmd = kcs_pkg::CMD_WRAP;
            kcs_pkg::S_SRCH_RD:  cmd = kcs_pkg::CMD_SRCH_RD;
            kcs_pkg::S_SRCH_CMP: cmd = kcs_pkg::CMD_SRCH_CMP;
            kcs_pkg::S_DIV:      cmd = kcs_pkg::CMD_DIV_STEP;
            kcs_pkg::S_RESULT:   cmd = kcs_pkg::CMD_INTERP;
            kcs_pkg::S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd = kcs_pkg::CMD_PUSH;
                end
            end
            default: cmd = kcs_pkg::CMD_NOP;
        endcase
    end

endmodule

// File: hw/rtl/kcs_datapath.sv
module kcs_datapath #(
    parameter int KEY_SLOTS = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  kcs_pkg::dp_cmd_t                    cmd,
    input  logic [kcs_pkg::IN_DATA_W-1:0]       in_data,
    input  logic                                cfg_valid,
    input  logic [kcs_pkg::COUNT_W-1:0]         cfg_data,
    input  logic                                out_ready,
    output kcs_pkg::dp_status_t                 status,
    output logic                                out_valid,
    output logic [kcs_pkg::OUT_DATA_W-1:0]      out_data
);

    localparam int AW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int CW = $clog2(KEY_SLOTS + 1);
    localparam int TW = kcs_pkg::TIME_W;
    localparam int VW = kcs_pkg::VALUE_W;
    localparam int MW = kcs_pkg::MAG_W;
    localparam int IW = kcs_pkg::ITER_W;

    logic [kcs_pkg::INDEX_W-1:0] ld_index;
    logic [TW-1:0]               ld_time;
    logic [VW-1:0]               ld_value;
    logic [TW-1:0]               in_query_time;
    logic [VW-1:0]               in_default;

    assign ld_index      = in_data[kcs_pkg::KEY_INDEX_LSB +: kcs_pkg::INDEX_W];
    assign ld_time       = in_data[kcs_pkg::KEY_TIME_LSB +: TW];
    assign ld_value      = in_data[kcs_pkg::KEY_VALUE_LSB +: VW];
    assign in_query_time = in_data[kcs_pkg::QUERY_TIME_LSB +: TW];
    assign in_default    = in_data[kcs_pkg::DEFAULT_VALUE_LSB +: VW];

    // Key store
    logic [TW-1:0] time_mem  [KEY_SLOTS];
    logic [VW-1:0] value_mem [KEY_SLOTS];
    logic [TW-1:0] mem_time_reg;
    logic [VW-1:0] mem_value_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic [kcs_pkg::COUNT_W-1:0] key_count_reg;
    logic [CW-1:0]               n_reg;
    logic [TW-1:0]               query_time_reg;
    logic [VW-1:0]               default_reg;
    logic [TW-1:0]               first_time_reg;
    logic [VW-1:0]               first_value_reg;
    logic [TW-1:0]               last_time_reg;
    logic [TW-1:0]               span_reg;
    logic                        below_reg;
    logic                        above_reg;
    logic [TW-1:0]               dividend_reg;
    logic [TW-1:0]               rem_reg;
    logic [IW-1:0]               iter_reg;
    logic [TW-1:0]               time_reg;
    logic [TW-1:0]               prev_time_reg;
    logic [VW-1:0]               prev_value_reg;
    logic [AW-1:0]               j_reg;
    logic [TW-1:0]               num_reg;
    logic [TW-1:0]               den_reg;
    logic [MW-1:0]               mag_reg;
    logic                        neg_reg;
    logic [VW-1:0]               base_reg;
    logic [TW-1:0]               acc_reg;
    logic [MW-1:0]               quot_reg;
    logic [VW-1:0]               res_value_reg;
    kcs_pkg::status_code_t       res_status_reg;
    logic [VW-1:0]               out_value_reg;
    kcs_pkg::status_code_t       out_status_reg;
    logic                        out_valid_reg;

    logic                        below;
    logic                        above;
    logic [TW:0]                 mod_trial;
    logic                        mod_ge;
    logic                        match;
    logic [MW-1:0]               diff;
    logic [TW+1:0]               div_sum;
    logic [TW+1:0]               den_once;
    logic [TW+1:0]               den_twice;
    logic [MW-1:0]               quot_shift;

    assign wr_en   = (cmd == kcs_pkg::CMD_LOAD) && (32'(ld_index) < KEY_SLOTS);
    assign wr_addr = AW'(ld_index);

    always_comb
    begin
        case (cmd)
            kcs_pkg::CMD_RD_LAST: rd_addr = AW'(n_reg - CW'(1));
            kcs_pkg::CMD_SRCH_RD: rd_addr = j_reg;
            default:              rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr]  <= ld_time;
            value_mem[wr_addr] <= ld_value;
        end
        mem_time_reg  <= time_mem[rd_addr];
        mem_value_reg <= value_mem[rd_addr];
    end

    assign below     = query_time_reg < first_time_reg;
    assign above     = query_time_reg > mem_time_reg;
    assign mod_trial = {rem_reg, dividend_reg[TW-1]};
    assign mod_ge    = mod_trial >= {1'b0, span_reg};
    assign match     = (prev_time_reg <= time_reg) && (time_reg <= mem_time_reg);
    assign diff      = {{2{mem_value_reg[VW-1]}}, mem_value_reg}
                     - {{2{prev_value_reg[VW-1]}}, prev_value_reg};
    assign div_sum   = {1'b0, acc_reg, 1'b0} + (mag_reg[MW-1] ? {2'b00, num_reg} : '0);
    assign den_once  = {2'b00, den_reg};
    assign den_twice = {1'b0, den_reg, 1'b0};
    assign quot_shift = {quot_reg[MW-2:0], 1'b0};

    always_ff @(posedge clk)
    begin
        case (cmd)
            kcs_pkg::CMD_CAPTURE:
            begin
                n_reg <= (32'(key_count_reg) > KEY_SLOTS) ? CW'(KEY_SLOTS)
                                                          : CW'(key_count_reg);
                query_time_reg <= in_query_time;
                default_reg    <= in_default;
            end
            kcs_pkg::CMD_RD_LAST:
            begin
                first_time_reg  <= mem_time_reg;
                first_value_reg <= mem_value_reg;
            end
            kcs_pkg::CMD_CHECK:
            begin
                last_time_reg <= mem_time_reg;
                span_reg      <= mem_time_reg - first_time_reg;
                below_reg     <= below;
                above_reg     <= above;
                dividend_reg  <= below ? first_time_reg - query_time_reg
                                       : query_time_reg - first_time_reg;
                rem_reg       <= '0;
                iter_reg      <= kcs_pkg::MOD_LAST_ITER;
                if (n_reg == '0)
                begin
                    res_value_reg  <= '0;
                    res_status_reg <= kcs_pkg::ST_NO_KEYS;
                end
                else if (n_reg == CW'(1))
                begin
                    res_value_reg  <= first_value_reg;
                    res_status_reg <= kcs_pkg::ST_SINGLE_KEY;
                end
                else
                begin
                    res_value_reg  <= first_value_reg;
                    res_status_reg <= kcs_pkg::ST_ZERO_SPAN;
                end
            end
            kcs_pkg::CMD_MOD_STEP:
            begin
                rem_reg      <= mod_ge ? TW'(mod_trial - {1'b0, span_reg}) : mod_trial[TW-1:0];
                dividend_reg <= {dividend_reg[TW-2:0], 1'b0};
                iter_reg     <= iter_reg - IW'(1);
            end
            kcs_pkg::CMD_WRAP:
            begin
                if (below_reg)
                begin
                    time_reg <= last_time_reg - rem_reg;
                end
                else if (above_reg)
                begin
                    time_reg <= first_time_reg + rem_reg;
                end
                else
                begin
                    time_reg <= query_time_reg;
                end
                prev_time_reg  <= first_time_reg;
                prev_value_reg <= first_value_reg;
                j_reg          <= AW'(1);
            end
            kcs_pkg::CMD_SRCH_CMP:
            begin
                if (match)
                begin
                    num_reg  <= time_reg - prev_time_reg;
                    den_reg  <= mem_time_reg - prev_time_reg;
                    neg_reg  <= diff[MW-1];
                    mag_reg  <= diff[MW-1] ? -diff : diff;
                    base_reg <= prev_value_reg;
                    acc_reg  <= '0;
                    quot_reg <= '0;
                    iter_reg <= kcs_pkg::DIV_LAST_ITER;
                end
                else
                begin
                    // Advance to the next segment; a miss on the last one gives the default
                    res_value_reg  <= default_reg;
                    res_status_reg <= kcs_pkg::ST_DEFAULT;
                    prev_time_reg  <= mem_time_reg;
                    prev_value_reg <= mem_value_reg;
                    j_reg          <= j_reg + AW'(1);
                end
            end
            kcs_pkg::CMD_DIV_STEP:
            begin
                if (div_sum >= den_twice)
                begin
                    acc_reg  <= TW'(div_sum - den_twice);
                    quot_reg <= quot_shift + MW'(2);
                end
                else if (div_sum >= den_once)
                begin
                    acc_reg  <= TW'(div_sum - den_once);
                    quot_reg <= quot_shift + MW'(1);
                end
                else
                begin
                    acc_reg  <= div_sum[TW-1:0];
                    quot_reg <= quot_shift;
                end
                mag_reg  <= {mag_reg[MW-2:0], 1'b0};
                iter_reg <= iter_reg - IW'(1);
            end
            kcs_pkg::CMD_INTERP:
            begin
                if (den_reg == '0)
                begin
                    res_value_reg <= base_reg;
                end
                else if (neg_reg)
                begin
                    res_value_reg <= base_reg - quot_reg[VW-1:0];
                end
                else
                begin
                    res_value_reg <= base_reg + quot_reg[VW-1:0];
                end
                res_status_reg <= kcs_pkg::ST_INTERP;
            end
            kcs_pkg::CMD_PUSH:
            begin
                out_value_reg  <= res_value_reg;
                out_status_reg <= res_status_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                key_count_reg <= cfg_data;
            end
            if (cmd == kcs_pkg::CMD_PUSH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.keys_zero   = (n_reg == '0);
    assign status.keys_one    = (n_reg == CW'(1));
    assign status.span_bad    = (mem_time_reg <= first_time_reg);
    assign status.wrap_needed = below || above;
    assign status.iter_zero   = (iter_reg == '0);
    assign status.match       = match;
    assign status.last_seg    = (j_reg == AW'(n_reg - CW'(1)));
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = {5'b0_0000, out_status_reg, out_value_reg};

endmodule

// File: test/keyframe_curve_sampler_tb.sv
class sample_scoreboard;

    // Copy of the curve state, updated as beats are accepted
    logic [47:0] key_times [64];
    logic [31:0] key_values [64];
    logic [6:0]  key_count;
    logic [31:0] exp_value_q [$];
    logic [2:0]  exp_status_q [$];
    int          mismatch_count;

    function void clear();
        key_count = '0;
        mismatch_count = 0;
        exp_value_q.delete();
        exp_status_q.delete();
    endfunction

    function int pending();
        return exp_value_q.size();
    endfunction

    // Scale a segment delta by (t - t0) / (t1 - t0), truncating toward zero
    function logic signed [31:0] lerp(logic [47:0] t, logic [47:0] t0, logic [47:0] t1,
                                      logic [31:0] v0, logic [31:0] v1);
        logic signed [33:0] diff;
        logic [33:0]        mag;
        logic [81:0]        prod;
        logic [81:0]        q;
        diff = $signed({{2{v1[31]}}, v1}) - $signed({{2{v0[31]}}, v0});
        mag  = diff[33] ? -diff : diff;
        if (t1 == t0)
            return v0;
        prod = {48'd0, mag} * {34'd0, t - t0};
        q    = prod / {34'd0, t1 - t0};
        if (diff[33])
            return $signed(v0) - $signed(q[31:0]);
        return $signed(v0) + $signed(q[31:0]);
    endfunction

    // Note an accepted input beat and queue the expected sample for a query
    function void note_input(logic kind, logic [5:0] idx, logic [47:0] ktime,
                             logic [31:0] kvalue, logic [47:0] qtime, logic [31:0] dflt);
        int          n;
        logic [47:0] first, last, span, t;
        logic [31:0] value;
        logic [2:0]  status;
        if (kind == kcs_pkg::KIND_LOAD)
        begin
            key_times[idx]  = ktime;
            key_values[idx] = kvalue;
            return;
        end
        n = (key_count > 64) ? 64 : key_count;
        value  = dflt;
        status = kcs_pkg::ST_DEFAULT;
        if (n == 0)
        begin
            value  = '0;
            status = kcs_pkg::ST_NO_KEYS;
        end
        else if (n == 1)
        begin
            value  = key_values[0];
            status = kcs_pkg::ST_SINGLE_KEY;
        end
        else
        begin
            first = key_times[0];
            last  = key_times[n-1];
            if (last <= first)
            begin
                value  = key_values[0];
                status = kcs_pkg::ST_ZERO_SPAN;
            end
            else
            begin
                span = last - first;
                t = qtime;
                if (t < first)
                    t = last - ((first - t) % span);
                else if (t > last)
                    t = first + ((t - first) % span);
                for (int i = 0; i + 1 < n; i++)
                begin
                    if (t >= key_times[i] && t <= key_times[i+1])
                    begin
                        value  = lerp(t, key_times[i], key_times[i+1],
                                      key_values[i], key_values[i+1]);
                        status = kcs_pkg::ST_INTERP;
                        break;
                    end
                end
            end
        end
        exp_value_q  = {exp_value_q, value};
        exp_status_q = {exp_status_q, status};
    endfunction

    function void check_result(logic [39:0] data);
        logic [31:0] ev;
        logic [2:0]  es;
        if (exp_value_q.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected sample beat: %h", data);
            return;
        end
        ev = exp_value_q.pop_front();
        es = exp_status_q.pop_front();
        if (data[31:0] !== ev || data[34:32] !== es || data[39:35] !== 5'd0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("sample mismatch: expected value %h status %0d, got value %h status %0d",
                         ev, es, data[31:0], data[34:32]);
        end
    endfunction

endclass

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [kcs_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [kcs_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [kcs_pkg::COUNT_W-1:0]    cfg_data = '0;

    sample_scoreboard board = new();
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   cycle_count = 0;
    int   loaded_slots = 0;     // slots 0..loaded_slots-1 hold written keys

    keyframe_curve_sampler_core #(.KEY_SLOTS(64)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    // Check output beats at the rising edge, pick the next stall at the falling edge
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (m_tvalid && m_tready)
            board.check_result(m_tdata);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Present one beat, hold it until accepted, then feed it to the scoreboard
    task automatic send_beat(logic kind, logic [5:0] idx, logic [47:0] ktime,
                             logic [31:0] kvalue, logic [47:0] qtime, logic [31:0] dflt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b0, dflt, qtime, kvalue, ktime, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_input(kind, idx, ktime, kvalue, qtime, dflt);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Write the key count while idle
    task automatic write_count(logic [6:0] count);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.key_count = count;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_load(int idx, logic [47:0] ktime, logic [31:0] kvalue);
        send_beat(kcs_pkg::KIND_LOAD, idx[5:0], ktime, kvalue, 48'({$urandom, $urandom}),
                  $urandom);
        if (idx >= loaded_slots)
            loaded_slots = idx + 1;
    endtask

    task automatic send_query(logic [47:0] qtime);
        send_beat(kcs_pkg::KIND_QUERY, 6'($urandom), 48'({$urandom, $urandom}), $urandom,
                  qtime, $urandom);
    endtask

    // Load a fresh curve of n keys; mostly ascending, sometimes shuffled
    task automatic load_curve(int n, logic [47:0] base, int max_step, bit ordered);
        logic [47:0] t;
        t = base;
        for (int i = 0; i < n; i++)
        begin
            send_load(i, ordered ? t : 48'({$urandom, $urandom}), $urandom);
            t = t + 48'($urandom_range(max_step));
        end
    endtask

    task automatic random_phase(int items);
        int n;
        int done;
        done = 0;
        while (done < items)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(64, 2) : $urandom_range(8, 2);
            if ($urandom_range(15) == 0)
                n = $urandom_range(1, 0);
            load_curve(n < 2 ? 2 : n, ($urandom_range(3) == 0) ? 48'hFFFF_0000_0000 :
                       48'({$urandom, $urandom} >> $urandom_range(47)),
                       ($urandom_range(1)) ? 1000 : 32'h7FFF_FFFF,
                       $urandom_range(7) != 0);
            // Count above the slots only once every slot holds a key
            write_count(($urandom_range(20) == 0 && loaded_slots == 64) ? 7'd127 : n[6:0]);
            for (int q = 0; q < 8; q++)
                send_query(48'({$urandom, $urandom}));
            done += (n < 2 ? 2 : n) + 8;
        end
    endtask

    initial
    begin
        board.clear();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: no keys, single key, zero span, extremes, out-of-order keys
        write_count(7'd0);
        send_query(48'h0);
        send_load(0, 48'h0, 32'h8000_0000);
        send_load(1, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF);
        write_count(7'd1);
        send_query(48'hFFFF_FFFF_FFFF);
        write_count(7'd2);
        send_query(48'h0);
        send_query(48'hFFFF_FFFF_FFFF);
        send_query(48'h8000_0000_0000);
        send_load(1, 48'h0, 32'h1234_5678);
        send_query(48'h5);                      // zero span
        send_load(0, 48'd100, 32'h7FFF_FFFF);
        send_load(1, 48'd200, 32'h8000_0000);
        send_load(2, 48'd200, 32'd5);           // zero-length segment
        send_load(3, 48'd300, 32'hFFFF_0000);
        write_count(7'd4);
        send_query(48'd7);                      // before span
        send_query(48'd999);                    // after span
        send_query(48'd200);
        send_query(48'd150);
        send_load(1, 48'd400, 32'd0);           // out of order: keys no longer ascending
        send_query(48'd250);
        send_query(48'd150);

        send_idle_pct = 15;
        recv_idle_pct = 84;
        random_phase(500);
        drain();                                // hold off until all samples are in
        send_idle_pct = 84;
        recv_idle_pct = 15;
        random_phase(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(500);
        write_count(7'd64);
        load_curve(64, 48'd0, 50, 1'b1);
        send_query(48'hFFFF_FFFF_FFFF);
        send_query(48'd1);

        drain();
        if (board.mismatch_count == 0 && board.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
